>>> rtl/shpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shpb_pkg: shared types and constants
// Request/response structs, register map, state codes and fixed widths of the
// sliding histogram percentile binarizer.
// ----------------------------------------------------------------------------
package shpb_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_WINDOW = 64;
    localparam int HIST_BINS      = 256;

    localparam int CNT_W = 13;   // histogram counter
    localparam int SUM_W = 21;   // cumulative count
    localparam int CRD_W = 14;   // signed coordinate
    localparam int DIM_W = 13;   // frame dimension / position
    localparam int WIN_W = 8;    // window side
    localparam int BIN_W = 8;

    localparam logic [9:0]  DEF_WIDTH  = 10'd0;
    localparam logic [10:0] RST_WIDTH  = 11'd1024;
    localparam logic [10:0] RST_HEIGHT = 11'd1024;
    localparam logic [6:0]  RST_WINDOW = 7'd40;
    localparam logic [6:0]  RST_RANK   = 7'd90;
    localparam logic [8:0]  RST_FACTOR = 9'd154;
    localparam logic [6:0]  RANK_MAX   = 7'd99;

    // floor(x/25) = (x * RCP_MUL) >> RCP_SHIFT for x below 2^19
    localparam logic [19:0] RCP_MUL   = 20'd671089;
    localparam int          RCP_SHIFT = 24;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_WINDOW = 3'd2,
        REG_RANK   = 3'd3,
        REG_FACTOR = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_COPY_IN,
        ST_UPD_FETCH,
        ST_UPD_HIST,
        ST_UPD_WRITE,
        ST_COPY_OUT,
        ST_SCAN,
        ST_PIX_FETCH,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_BUILD,
        MODE_ROW,
        MODE_COL
    } mode_t;

    typedef struct packed {
        logic       kind;
        logic [9:0] pixel_row;
        logic [9:0] pixel_col;
        logic [7:0] pixel_value;
    } req_t;

    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic [7:0] percentile_value;
        logic       binary_white;
        logic       last_of_frame;
    } rsp_t;

    typedef struct packed {
        logic       en;
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] value;
    } fs_wr_t;

    typedef struct packed {
        logic                    en;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] x;
    } fs_rd_t;

endpackage

>>> rtl/shpb_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shpb_frame_store: pixel frame memory
// Byte store with one write port and one registered read port. Read
// coordinates are clamped to the active frame (replicated border).
// ----------------------------------------------------------------------------
module shpb_frame_store #(
    parameter int MAX_WIDTH  = shpb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = shpb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         clk,
    input  shpb_pkg::fs_wr_t             wr,
    input  shpb_pkg::fs_rd_t             rd,
    input  logic [shpb_pkg::DIM_W-1:0]   width,
    input  logic [shpb_pkg::DIM_W-1:0]   height,
    output logic [7:0]                   rd_data
);
    import shpb_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] mem [DEPTH];

    logic signed [CRD_W-1:0] wm1;
    logic signed [CRD_W-1:0] hm1;
    logic signed [CRD_W-1:0] yc;
    logic signed [CRD_W-1:0] xc;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    wr_ok;

    always_comb
    begin
        wm1 = $signed({1'b0, width}) - CRD_W'(1);
        hm1 = $signed({1'b0, height}) - CRD_W'(1);
        yc  = rd.y;
        xc  = rd.x;
        if (yc < 0)
        begin
            yc = '0;
        end
        if (yc > hm1)
        begin
            yc = hm1;
        end
        if (xc < 0)
        begin
            xc = '0;
        end
        if (xc > wm1)
        begin
            xc = wm1;
        end
        rd_addr = ADDR_W'(yc) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xc);
        wr_addr = ADDR_W'(wr.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(wr.col);
        wr_ok   = (32'(wr.row) < 32'(MAX_HEIGHT)) && (32'(wr.col) < 32'(MAX_WIDTH));
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_ok)
        begin
            mem[wr_addr] <= wr.value;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/sliding_histogram_percentile_binarizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_histogram_percentile_binarizer: windowed percentile and threshold
// Frame store plus running 256-bin window histogram in block memory; each
// compute request yields the window percentile and a binarized pixel.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data (req_t)
//   rsp      out        rsp_valid / rsp_ready  rsp_data (rsp_t)
//   cfg      in         cfg_write              cfg_index, cfg_data
//
// Pixel write: stored on the request handshake. Column step: 2*ws updates
// (one serial read-modify-write per histogram update), then the 256-bin
// scan. Row start: adds two histogram copies. Frame start: 256-bin clear +
// ws*ws updates + copy + scan. Reset clears control only; memories need none.
// A response waiting on rsp_ready holds the block in its final state.
// ----------------------------------------------------------------------------
module sliding_histogram_percentile_binarizer #(
    parameter int MAX_WIDTH  = shpb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = shpb_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = shpb_pkg::DEF_MAX_WINDOW
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  shpb_pkg::req_t    req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output shpb_pkg::rsp_t    rsp_data,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [10:0]       cfg_data
);
    import shpb_pkg::*;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    logic [10:0] width_reg, width_next;
    logic [10:0] height_reg, height_next;
    logic [6:0]  window_reg, window_next;
    logic [6:0]  rank_reg, rank_next;
    logic [8:0]  factor_reg, factor_next;

    logic [DIM_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [WIN_W-1:0] a_reg, a_next;
    logic [WIN_W-1:0] b_reg, b_next;
    logic             ph_reg, ph_next;
    logic [8:0]       cnt_reg, cnt_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [BIN_W-1:0] perc_reg, perc_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic [15:0]      n_reg;
    logic [22:0]      np_reg;
    logic [30:0]      pp_lo_reg;
    logic [30:0]      pp_hi_reg;
    logic [SUM_W-1:0] target_reg;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [WIN_W-1:0] ws_eff, pad;
    logic [6:0]       rank_eff;
    logic [20:0]      np_q;
    logic [40:0]      prod;

    logic signed [CRD_W-1:0] r_s, c_s, a_s, b_s, pad_s, ws_s;
    fs_rd_t fs_rd;
    fs_wr_t fs_wr;
    logic [7:0] fs_rd_data;

    logic [CNT_W-1:0] win_mem [HIST_BINS];
    logic [CNT_W-1:0] rs_mem [HIST_BINS];
    logic [CNT_W-1:0] win_rd_data;
    logic [CNT_W-1:0] rs_rd_data;
    logic             win_rd_en, win_we, rs_rd_en, rs_we;
    logic [BIN_W-1:0] win_rd_addr, win_wr_addr, rs_rd_addr, rs_wr_addr, cnt_m1;
    logic [CNT_W-1:0] win_wr_data;

    logic             req_fire, start, upd_last, rsp_free, found;
    logic [DIM_W-1:0] r_start, c_start;
    logic [SUM_W-1:0] sum_add;
    logic [16:0]      thr_lhs, thr_rhs;

    // effective configuration
    always_comb
    begin
        w_eff = {2'b0, width_reg};
        if (w_eff == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (32'(w_eff) > MAX_WIDTH)
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        h_eff = {2'b0, height_reg};
        if (h_eff == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (32'(h_eff) > MAX_HEIGHT)
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
        ws_eff = {1'b0, window_reg};
        if (ws_eff == '0)
        begin
            ws_eff = WIN_W'(1);
        end
        else if (32'(ws_eff) > MAX_WINDOW)
        begin
            ws_eff = WIN_W'(MAX_WINDOW);
        end
        rank_eff = (rank_reg > RANK_MAX) ? RANK_MAX : rank_reg;
        pad      = ws_eff >> 1;
    end

    // rank target n*p/100 + 1, registered through n_reg, np_reg, pp_lo/pp_hi_reg and target_reg
    assign np_q = np_reg[22:2];
    assign prod = {pp_hi_reg, 10'b0} + 41'(pp_lo_reg);

    always_ff @(posedge clk)
    begin
        n_reg      <= 16'(ws_eff) * 16'(ws_eff);
        np_reg     <= 23'(n_reg) * 23'(rank_eff);
        pp_lo_reg  <= 31'(np_q) * 31'(RCP_MUL[9:0]);
        pp_hi_reg  <= 31'(np_q) * 31'(RCP_MUL[19:10]);
        target_reg <= SUM_W'(prod[40:RCP_SHIFT]) + SUM_W'(1);
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign start     = req_fire && (req_data.kind == KIND_COMPUTE);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign cnt_m1    = 8'(cnt_reg - 9'd1);

    assign r_start = (row_reg >= h_eff || col_reg >= w_eff) ? '0 : row_reg;
    assign c_start = (row_reg >= h_eff || col_reg >= w_eff) ? '0 : col_reg;

    assign upd_last = (a_reg == ws_eff - WIN_W'(1)) &&
                      ((mode_reg == MODE_BUILD) ? (b_reg == ws_eff - WIN_W'(1)) : ph_reg);

    assign sum_add = sum_reg + SUM_W'(win_rd_data);
    assign found   = (cnt_reg != '0) && (sum_add >= target_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (r_start == '0 && c_start == '0)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (c_start == '0)
                    begin
                        state_next = ST_COPY_IN;
                    end
                    else
                    begin
                        state_next = ST_UPD_FETCH;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (cnt_reg == 9'd255)
                begin
                    state_next = ST_UPD_FETCH;
                end
            end
            ST_COPY_IN:
            begin
                if (cnt_reg == 9'd256)
                begin
                    state_next = ST_UPD_FETCH;
                end
            end
            ST_UPD_FETCH: state_next = ST_UPD_HIST;
            ST_UPD_HIST:  state_next = ST_UPD_WRITE;
            ST_UPD_WRITE:
            begin
                if (!upd_last)
                begin
                    state_next = ST_UPD_FETCH;
                end
                else if (mode_reg == MODE_COL)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_COPY_OUT;
                end
            end
            ST_COPY_OUT:
            begin
                if (cnt_reg == 9'd256)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (found || cnt_reg == 9'd256)
                begin
                    state_next = ST_PIX_FETCH;
                end
            end
            ST_PIX_FETCH: state_next = ST_DONE;
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        width_next     = width_reg;
        height_next    = height_reg;
        window_next    = window_reg;
        rank_next      = rank_reg;
        factor_next    = factor_reg;
        mode_next      = mode_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ph_next        = ph_reg;
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        sum_next       = sum_reg;
        perc_next      = perc_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        r_s   = $signed({1'b0, row_reg});
        c_s   = $signed({1'b0, col_reg});
        a_s   = $signed(CRD_W'(a_reg));
        b_s   = $signed(CRD_W'(b_reg));
        pad_s = $signed(CRD_W'(pad));
        ws_s  = $signed(CRD_W'(ws_eff));

        fs_rd.en = (state_reg == ST_UPD_FETCH) || (state_reg == ST_PIX_FETCH);
        fs_rd.y  = r_s;
        fs_rd.x  = c_s;
        if (state_reg == ST_UPD_FETCH)
        begin
            unique case (mode_reg)
                MODE_BUILD:
                begin
                    fs_rd.y = a_s - pad_s;
                    fs_rd.x = b_s - pad_s;
                end
                MODE_ROW:
                begin
                    fs_rd.y = ph_reg ? (r_s - pad_s + ws_s - CRD_W'(1))
                                     : (r_s - CRD_W'(1) - pad_s);
                    fs_rd.x = a_s - pad_s;
                end
                MODE_COL:
                begin
                    fs_rd.y = r_s - pad_s + a_s;
                    fs_rd.x = ph_reg ? (c_s - pad_s + ws_s - CRD_W'(1))
                                     : (c_s - CRD_W'(1) - pad_s);
                end
                default:
                begin
                    fs_rd.y = r_s;
                    fs_rd.x = c_s;
                end
            endcase
        end

        fs_wr.en    = req_fire && (req_data.kind == KIND_WRITE);
        fs_wr.row   = req_data.pixel_row;
        fs_wr.col   = req_data.pixel_col;
        fs_wr.value = req_data.pixel_value;

        win_rd_en   = 1'b0;
        win_rd_addr = cnt_reg[7:0];
        win_we      = 1'b0;
        win_wr_addr = cnt_m1;
        win_wr_data = rs_rd_data;
        rs_rd_en    = 1'b0;
        rs_rd_addr  = cnt_reg[7:0];
        rs_we       = 1'b0;
        rs_wr_addr  = cnt_m1;

        thr_lhs = {1'b0, fs_rd_data, 8'b0};
        thr_rhs = 17'(factor_reg) * 17'(perc_reg);

        if (cfg_write)
        begin
            case (cfg_index)
                REG_WIDTH:  width_next  = cfg_data;
                REG_HEIGHT: height_next = cfg_data;
                REG_WINDOW: window_next = cfg_data[6:0];
                REG_RANK:   rank_next   = cfg_data[6:0];
                REG_FACTOR: factor_next = cfg_data[8:0];
                default: ;
            endcase
            if (cfg_index <= REG_FACTOR)
            begin
                row_next = '0;
                col_next = '0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    row_next = r_start;
                    col_next = c_start;
                    a_next   = '0;
                    b_next   = '0;
                    ph_next  = 1'b0;
                    cnt_next = '0;
                    if (r_start == '0 && c_start == '0)
                    begin
                        mode_next = MODE_BUILD;
                    end
                    else if (c_start == '0)
                    begin
                        mode_next = MODE_ROW;
                    end
                    else
                    begin
                        mode_next = MODE_COL;
                    end
                end
            end
            ST_CLEAR:
            begin
                win_we      = 1'b1;
                win_wr_addr = cnt_reg[7:0];
                win_wr_data = '0;
                cnt_next    = (cnt_reg == 9'd255) ? '0 : cnt_reg + 9'd1;
            end
            ST_COPY_IN:
            begin
                rs_rd_en = 1'b1;
                win_we   = (cnt_reg != '0);
                cnt_next = (cnt_reg == 9'd256) ? '0 : cnt_reg + 9'd1;
            end
            ST_UPD_FETCH: ;
            ST_UPD_HIST:
            begin
                win_rd_en   = 1'b1;
                win_rd_addr = fs_rd_data;
                bin_next    = fs_rd_data;
            end
            ST_UPD_WRITE:
            begin
                win_we      = 1'b1;
                win_wr_addr = bin_reg;
                win_wr_data = (mode_reg == MODE_BUILD || ph_reg) ?
                              win_rd_data + CNT_W'(1) : win_rd_data - CNT_W'(1);
                if (mode_reg == MODE_BUILD)
                begin
                    if (b_reg == ws_eff - WIN_W'(1))
                    begin
                        b_next = '0;
                        a_next = a_reg + WIN_W'(1);
                    end
                    else
                    begin
                        b_next = b_reg + WIN_W'(1);
                    end
                end
                else
                begin
                    ph_next = !ph_reg;
                    if (ph_reg)
                    begin
                        a_next = a_reg + WIN_W'(1);
                    end
                end
                cnt_next = '0;
                sum_next = '0;
            end
            ST_COPY_OUT:
            begin
                win_rd_en = 1'b1;
                rs_we     = (cnt_reg != '0);
                cnt_next  = (cnt_reg == 9'd256) ? '0 : cnt_reg + 9'd1;
                sum_next  = '0;
            end
            ST_SCAN:
            begin
                win_rd_en = 1'b1;
                if (cnt_reg != '0)
                begin
                    sum_next = sum_add;
                end
                if (found)
                begin
                    perc_next = cnt_m1;
                end
                else if (cnt_reg == 9'd256)
                begin
                    perc_next = 8'd255;
                end
                cnt_next = cnt_reg + 9'd1;
            end
            ST_PIX_FETCH: ;
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.out_row          = row_reg[9:0];
                    rsp_next.out_col          = col_reg[9:0];
                    rsp_next.percentile_value = perc_reg;
                    rsp_next.binary_white     = !(thr_lhs < thr_rhs);
                    rsp_next.last_of_frame    = (row_reg == h_eff - DIM_W'(1)) &&
                                                (col_reg == w_eff - DIM_W'(1));
                    if (col_reg + DIM_W'(1) < w_eff)
                    begin
                        col_next = col_reg + DIM_W'(1);
                    end
                    else
                    begin
                        col_next = '0;
                        row_next = (row_reg + DIM_W'(1) < h_eff) ?
                                   row_reg + DIM_W'(1) : '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_BUILD;
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            window_reg    <= RST_WINDOW;
            rank_reg      <= RST_RANK;
            factor_reg    <= RST_FACTOR;
            row_reg       <= '0;
            col_reg       <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            ph_reg        <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            window_reg    <= window_next;
            rank_reg      <= rank_next;
            factor_reg    <= factor_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            ph_reg        <= ph_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        sum_reg  <= sum_next;
        perc_reg <= perc_next;
        rsp_reg  <= rsp_next;
    end

    // histogram memories
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[win_wr_addr] <= win_wr_data;
        end
        if (win_rd_en)
        begin
            win_rd_data <= win_mem[win_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
        begin
            rs_mem[rs_wr_addr] <= win_rd_data;
        end
        if (rs_rd_en)
        begin
            rs_rd_data <= rs_mem[rs_rd_addr];
        end
    end

    shpb_frame_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_frame_store (
        .clk     (clk),
        .wr      (fs_wr),
        .rd      (fs_rd),
        .width   (w_eff),
        .height  (h_eff),
        .rd_data (fs_rd_data)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule
